// ===== hdl/tsbo_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, codes and controller/datapath structs for the timestamp seek block.
package tsbo_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned SegW     = 47;
  localparam int unsigned TotW     = 57;
  localparam int unsigned TotSumW  = TotW + 11;
  localparam int unsigned OffW     = 63;
  localparam int unsigned StW      = 2;
  localparam int unsigned ColW     = 2;
  localparam int unsigned ProdW    = CfgW + TotW;
  localparam int unsigned DivCntW  = $clog2(ProdW);
  localparam int unsigned MaxLenDef = 14;

  localparam logic [SegW-1:0] SegMax = {SegW{1'b1}};
  localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};
  localparam logic [OffW-1:0] OffMax = {OffW{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgFileSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDuration = 1'b1;

  localparam logic [StW-1:0] StOk     = 2'd0;
  localparam logic [StW-1:0] StBad    = 2'd1;
  localparam logic [StW-1:0] StNoSeek = 2'd2;

  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChColon = 8'h3A;
  localparam logic [ChW-1:0] ChDot   = 8'h2E;

  localparam logic [ColW-1:0] MaxColons = 2'd2;

  typedef enum logic [1:0] {
    TOT_HM = 2'd0,
    TOT_S  = 2'd1,
    TOT_MS = 2'd2
  } tot_sel_t;

  typedef struct packed {
    logic     take_char;
    logic     finish;
    logic     tot_en;
    tot_sel_t tot_sel;
    logic     mul_en;
    logic     mul_hi;
    logic     div_en;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic fmt_bad;
    logic seekable;
    logic div_last;
    logic out_full;
  } sts_t;

endpackage

// ===== hdl/tsbo_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences parsing, total, multiply, divide and result load.
module tsbo_ctrl import tsbo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CHAR  = 9'b000000001,
    S_FINAL = 9'b000000010,
    S_TOT0  = 9'b000000100,
    S_TOT1  = 9'b000001000,
    S_TOT2  = 9'b000010000,
    S_MUL0  = 9'b000100000,
    S_MUL1  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_LOAD  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CHAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CHAR: begin
        cmd.take_char = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        state_nxt  = S_TOT0;
      end
      S_TOT0: begin
        cmd.tot_en  = 1'b1;
        cmd.tot_sel = TOT_HM;
        state_nxt   = S_TOT1;
      end
      S_TOT1: begin
        cmd.tot_en  = 1'b1;
        cmd.tot_sel = TOT_S;
        state_nxt   = S_TOT2;
      end
      S_TOT2: begin
        cmd.tot_en  = 1'b1;
        cmd.tot_sel = TOT_MS;
        if (sts.fmt_bad || !sts.seekable) begin
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_CHAR;
        end
      end
      default: begin
        state_nxt = S_CHAR;
      end
    endcase
  end

  assign in_stall = (state_r != S_CHAR);

endmodule

// ===== hdl/tsbo_dp.sv =====
`timescale 1ns / 1ps
// Datapath with parse registers, total unit, shared multiplier, serial divider and result register.
module tsbo_dp import tsbo_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [ChW-1:0]       in_ch,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]      cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [StW-1:0]       out_status,
  output logic [SegW-1:0]      out_hours,
  output logic [SegW-1:0]      out_minutes,
  output logic [SegW-1:0]      out_seconds,
  output logic [SegW-1:0]      out_millis,
  output logic [TotW-1:0]      out_target_ms,
  output logic [OffW-1:0]      out_byte_offset
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  logic [CfgW-1:0] file_size_r;
  logic [CfgW-1:0] duration_r;

  logic [SegW-1:0] acc_r, acc_nxt;
  logic [SegW-1:0] hours_r, hours_nxt;
  logic [SegW-1:0] minutes_r, minutes_nxt;
  logic [SegW-1:0] seconds_r, seconds_nxt;
  logic [SegW-1:0] millis_r, millis_nxt;
  logic [ColW-1:0] colon_cnt_r, colon_cnt_nxt;
  logic            dot_seen_r, dot_seen_nxt;
  logic [CntW-1:0] char_cnt_r, char_cnt_nxt;
  logic            seg_empty_r, seg_empty_nxt;
  logic            format_bad_r, format_bad_nxt;

  logic            is_digit;
  logic [SegW+3:0] acc_x10;

  logic [TotW-1:0]    tot_r;
  logic               tot_ovf_r;
  logic [TotW-1:0]    tot_base;
  logic [SegW-1:0]    tot_add;
  logic               tot_k1000;
  logic [TotSumW-1:0] tot_x;
  logic [TotSumW-1:0] tot_sum;
  logic [TotW-1:0]    total_final;

  logic [CfgW-1:0]   mul_b;
  logic [2*CfgW-1:0] pp;
  logic [ProdW-1:0]  prod_r;

  logic [CfgW-1:0]    rem_r;
  logic [OffW-1:0]    quo_r;
  logic               quo_ovf_r;
  logic [DivCntW-1:0] div_cnt_r;
  logic [CfgW:0]      trial;
  logic [CfgW:0]      trial_diff;
  logic               trial_ge;

  logic            seekable;
  logic            out_valid_r;
  logic [StW-1:0]  out_status_r;
  logic [SegW-1:0] out_hours_r;
  logic [SegW-1:0] out_minutes_r;
  logic [SegW-1:0] out_seconds_r;
  logic [SegW-1:0] out_millis_r;
  logic [TotW-1:0] out_total_r;
  logic [OffW-1:0] out_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
      duration_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgFileSize: file_size_r <= cfg_data;
        CfgDuration: duration_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign is_digit = (in_ch >= ChZero) && (in_ch <= ChNine);
  assign acc_x10  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + (SegW + 4)'(in_ch[3:0]);

  always_comb begin
    acc_nxt        = acc_r;
    hours_nxt      = hours_r;
    minutes_nxt    = minutes_r;
    seconds_nxt    = seconds_r;
    millis_nxt     = millis_r;
    colon_cnt_nxt  = colon_cnt_r;
    dot_seen_nxt   = dot_seen_r;
    char_cnt_nxt   = char_cnt_r;
    seg_empty_nxt  = seg_empty_r;
    format_bad_nxt = format_bad_r;
    if (cmd.take_char) begin
      if (char_cnt_r >= CntW'(MAX_LEN)) begin
        format_bad_nxt = 1'b1;
      end else begin
        char_cnt_nxt = char_cnt_r + CntW'(1);
      end
      if (!format_bad_nxt) begin
        if (is_digit) begin
          if (acc_x10[SegW+3:SegW] != 4'd0) begin
            acc_nxt = SegMax;
          end else begin
            acc_nxt = acc_x10[SegW-1:0];
          end
          seg_empty_nxt = 1'b0;
        end else if (in_ch == ChColon) begin
          if (dot_seen_r || (colon_cnt_r == MaxColons) || seg_empty_r) begin
            format_bad_nxt = 1'b1;
          end else begin
            hours_nxt     = minutes_r;
            minutes_nxt   = seconds_r;
            seconds_nxt   = acc_r;
            acc_nxt       = '0;
            seg_empty_nxt = 1'b1;
            colon_cnt_nxt = colon_cnt_r + ColW'(1);
          end
        end else if (in_ch == ChDot) begin
          if (dot_seen_r || seg_empty_r) begin
            format_bad_nxt = 1'b1;
          end else begin
            hours_nxt     = minutes_r;
            minutes_nxt   = seconds_r;
            seconds_nxt   = acc_r;
            acc_nxt       = '0;
            seg_empty_nxt = 1'b1;
            dot_seen_nxt  = 1'b1;
          end
        end else begin
          format_bad_nxt = 1'b1;
        end
      end
    end else if (cmd.finish) begin
      if (format_bad_r || seg_empty_r) begin
        format_bad_nxt = 1'b1;
      end else if (dot_seen_r) begin
        millis_nxt = acc_r;
      end else begin
        hours_nxt   = minutes_r;
        minutes_nxt = seconds_r;
        seconds_nxt = acc_r;
      end
    end else if (cmd.load_out) begin
      acc_nxt        = '0;
      hours_nxt      = '0;
      minutes_nxt    = '0;
      seconds_nxt    = '0;
      millis_nxt     = '0;
      colon_cnt_nxt  = '0;
      dot_seen_nxt   = 1'b0;
      char_cnt_nxt   = '0;
      seg_empty_nxt  = 1'b1;
      format_bad_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      hours_r      <= '0;
      minutes_r    <= '0;
      seconds_r    <= '0;
      millis_r     <= '0;
      colon_cnt_r  <= '0;
      dot_seen_r   <= 1'b0;
      char_cnt_r   <= '0;
      seg_empty_r  <= 1'b1;
      format_bad_r <= 1'b0;
    end else begin
      acc_r        <= acc_nxt;
      hours_r      <= hours_nxt;
      minutes_r    <= minutes_nxt;
      seconds_r    <= seconds_nxt;
      millis_r     <= millis_nxt;
      colon_cnt_r  <= colon_cnt_nxt;
      dot_seen_r   <= dot_seen_nxt;
      char_cnt_r   <= char_cnt_nxt;
      seg_empty_r  <= seg_empty_nxt;
      format_bad_r <= format_bad_nxt;
    end
  end

  // The total is built as ((hours*60 + minutes)*60 + seconds)*1000 + millis.
  always_comb begin
    case (cmd.tot_sel)
      TOT_HM: begin
        tot_base  = TotW'(hours_r);
        tot_add   = minutes_r;
        tot_k1000 = 1'b0;
      end
      TOT_S: begin
        tot_base  = tot_r;
        tot_add   = seconds_r;
        tot_k1000 = 1'b0;
      end
      TOT_MS: begin
        tot_base  = tot_r;
        tot_add   = millis_r;
        tot_k1000 = 1'b1;
      end
      default: begin
        tot_base  = tot_r;
        tot_add   = '0;
        tot_k1000 = 1'b0;
      end
    endcase
  end

  assign tot_x   = TotSumW'(tot_base);
  assign tot_sum = (tot_k1000 ? ((tot_x << 10) - (tot_x << 4) - (tot_x << 3))
                              : ((tot_x << 6) - (tot_x << 2))) + TotSumW'(tot_add);
  assign total_final = tot_ovf_r ? TotMax : tot_r;

  always_ff @(posedge clk) begin
    if (cmd.tot_en) begin
      tot_r     <= tot_sum[TotW-1:0];
      tot_ovf_r <= ((cmd.tot_sel != TOT_HM) && tot_ovf_r) ||
                   (tot_sum[TotSumW-1:TotW] != '0);
    end
  end

  assign mul_b = cmd.mul_hi ? CfgW'(total_final[TotW-1:CfgW]) : total_final[CfgW-1:0];
  assign pp    = file_size_r * mul_b;

  assign trial      = {rem_r, prod_r[ProdW-1]};
  assign trial_diff = trial - {1'b0, duration_r};
  assign trial_ge   = (trial >= {1'b0, duration_r});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_hi) begin
        prod_r    <= prod_r + {pp[ProdW-CfgW-1:0], CfgW'(0)};
        rem_r     <= '0;
        quo_r     <= '0;
        quo_ovf_r <= 1'b0;
        div_cnt_r <= DivCntW'(ProdW - 1);
      end else begin
        prod_r <= ProdW'(pp);
      end
    end else if (cmd.div_en) begin
      prod_r    <= {prod_r[ProdW-2:0], 1'b0};
      rem_r     <= trial_ge ? trial_diff[CfgW-1:0] : trial[CfgW-1:0];
      quo_r     <= {quo_r[OffW-2:0], trial_ge};
      quo_ovf_r <= quo_ovf_r || quo_r[OffW-1];
      div_cnt_r <= div_cnt_r - DivCntW'(1);
    end
  end

  assign seekable = (file_size_r != '0) && (duration_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (format_bad_r) begin
        out_status_r  <= StBad;
        out_hours_r   <= '0;
        out_minutes_r <= '0;
        out_seconds_r <= '0;
        out_millis_r  <= '0;
        out_total_r   <= '0;
        out_offset_r  <= '0;
      end else begin
        out_status_r  <= seekable ? StOk : StNoSeek;
        out_hours_r   <= hours_r;
        out_minutes_r <= minutes_r;
        out_seconds_r <= seconds_r;
        out_millis_r  <= millis_r;
        out_total_r   <= total_final;
        if (!seekable) begin
          out_offset_r <= '0;
        end else if (quo_ovf_r) begin
          out_offset_r <= OffMax;
        end else begin
          out_offset_r <= quo_r;
        end
      end
    end
  end

  assign sts.fmt_bad  = format_bad_r;
  assign sts.seekable = seekable;
  assign sts.div_last = (div_cnt_r == '0);
  assign sts.out_full = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hours       = out_hours_r;
  assign out_minutes     = out_minutes_r;
  assign out_seconds     = out_seconds_r;
  assign out_millis      = out_millis_r;
  assign out_target_ms   = out_total_r;
  assign out_byte_offset = out_offset_r;

`ifndef NO_ASSERTIONS
  a_char_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    char_cnt_r <= CntW'(MAX_LEN))
    else $error("Character count ran past the length limit.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("Result register loaded while a result is still stalled.");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("Result valid rose without a load.");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_en |-> (rem_r < duration_r))
    else $error("Divider remainder is not below the duration.");
`endif

endmodule

// ===== hdl/timestamp_text_to_byte_offset_top.sv =====
`timescale 1ns / 1ps
// Top level of the seek timestamp parser and byte offset calculator.
//
//   Channel | Role                  | Ports
//   --------+-----------------------+-------------------------------------------------
//   in      | timestamp characters  | in_valid, in_stall, in_ch, in_last
//   out     | seek result           | out_valid, out_stall, out_status, out_hours,
//           |                       | out_minutes, out_seconds, out_millis,
//           |                       | out_target_ms, out_byte_offset
//   cfg     | register write        | cfg_we, cfg_index, cfg_data
//
// Characters are taken one per cycle while in_stall is low. After a request's last
// character the input stalls through the parse finish and total; an invalid or unseekable
// timestamp then loads, else the 32x32 multiply and bit-serial 89-step divider run first.
// A result that waits on out_stall holds the input stalled only once the next request
// reaches its final load. Reset is synchronous on rst_n and clears all parse state.
module timestamp_text_to_byte_offset_top import tsbo_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ChW-1:0]     in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [StW-1:0]     out_status,
  output logic [SegW-1:0]    out_hours,
  output logic [SegW-1:0]    out_minutes,
  output logic [SegW-1:0]    out_seconds,
  output logic [SegW-1:0]    out_millis,
  output logic [TotW-1:0]    out_target_ms,
  output logic [OffW-1:0]    out_byte_offset,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;

  tsbo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tsbo_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_ch           (in_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_hours       (out_hours),
    .out_minutes     (out_minutes),
    .out_seconds     (out_seconds),
    .out_millis      (out_millis),
    .out_target_ms   (out_target_ms),
    .out_byte_offset (out_byte_offset)
  );

endmodule

// ===== tb/sv/tsbo_seek_sb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the timestamp seek block: predicts seek results and checks them in order.
package tsbo_seek_sb_pkg;
  import tsbo_pkg::*;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [SegW-1:0] hours;
    logic [SegW-1:0] minutes;
    logic [SegW-1:0] seconds;
    logic [SegW-1:0] millis;
    logic [TotW-1:0] target_ms;
    logic [OffW-1:0] byte_offset;
  } seek_result_t;

  class seek_scoreboard;
    logic [CfgW-1:0] file_size;
    logic [CfgW-1:0] duration_ms;
    logic [SegW-1:0] seg_val [4];
    logic [SegW-1:0] digit_acc;
    logic [ColW-1:0] colons;
    bit dot_seen;
    bit seg_empty;
    bit fmt_bad;
    int unsigned char_cnt;
    seek_result_t expected_q[$];
    int unsigned mismatches;
    int unsigned seeks_ok;
    int unsigned seeks_bad;
    int unsigned seeks_noseek;

    function new();
      file_size = '0;
      duration_ms = '0;
      mismatches = 0;
      seeks_ok = 0;
      seeks_bad = 0;
      seeks_noseek = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      foreach (seg_val[k]) seg_val[k] = '0;
      digit_acc = '0;
      colons = '0;
      dot_seen = 1'b0;
      seg_empty = 1'b1;
      fmt_bad = 1'b0;
      char_cnt = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      if (idx == CfgFileSize) begin
        file_size = val;
      end else if (idx == CfgDuration) begin
        duration_ms = val;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void close_seg(int unsigned idx);
      seg_val[idx] = digit_acc;
      digit_acc = '0;
      seg_empty = 1'b1;
    endfunction

    function void note_char(logic [ChW-1:0] c, logic is_last);
      logic [SegW+3:0] grown;
      logic [71:0] sum;
      logic [95:0] quot;
      seek_result_t r;
      if (char_cnt >= MaxLenDef) begin
        fmt_bad = 1'b1;
      end else begin
        char_cnt++;
      end
      if (!fmt_bad) begin
        if (c >= ChZero && c <= ChNine) begin
          grown = {4'b0, digit_acc} * 10 + (c - ChZero);
          digit_acc = (grown > SegMax) ? SegMax : grown[SegW-1:0];
          seg_empty = 1'b0;
        end else if (c == ChColon) begin
          if (dot_seen || colons >= MaxColons || seg_empty) begin
            fmt_bad = 1'b1;
          end else begin
            close_seg(colons);
            colons++;
          end
        end else if (c == ChDot) begin
          if (dot_seen || seg_empty) begin
            fmt_bad = 1'b1;
          end else begin
            close_seg(colons);
            dot_seen = 1'b1;
          end
        end else begin
          fmt_bad = 1'b1;
        end
      end
      if (!is_last) return;
      if (!fmt_bad && seg_empty) fmt_bad = 1'b1;
      if (!fmt_bad) close_seg(dot_seen ? 3 : colons);
      r = '0;
      if (fmt_bad) begin
        r.status = StBad;
        seeks_bad++;
      end else begin
        r.hours = (colons == 2) ? seg_val[0] : '0;
        r.minutes = (colons >= 1) ? seg_val[colons - 1] : '0;
        r.seconds = seg_val[colons];
        r.millis = dot_seen ? seg_val[3] : '0;
        sum = 72'(r.millis) + 72'(r.seconds) * 1000 + 72'(r.minutes) * 60000
            + 72'(r.hours) * 3600000;
        r.target_ms = (sum > TotMax) ? TotMax : sum[TotW-1:0];
        if (file_size == 0 || duration_ms == 0) begin
          r.status = StNoSeek;
          seeks_noseek++;
        end else begin
          quot = (96'(file_size) * 96'(r.target_ms)) / 96'(duration_ms);
          r.byte_offset = (quot > OffMax) ? OffMax : quot[OffW-1:0];
          r.status = StOk;
          seeks_ok++;
        end
      end
      expected_q.push_back(r);
      clear_parse();
    endfunction

    function void check_result(seek_result_t got);
      seek_result_t want;
      string diff;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected seek result with status %0d", got.status);
        return;
      end
      want = expected_q.pop_front();
      diff = "";
      if (got.status !== want.status) diff = {diff, " status"};
      if (got.hours !== want.hours) diff = {diff, " hours"};
      if (got.minutes !== want.minutes) diff = {diff, " minutes"};
      if (got.seconds !== want.seconds) diff = {diff, " seconds"};
      if (got.millis !== want.millis) diff = {diff, " millis"};
      if (got.target_ms !== want.target_ms) diff = {diff, " target_ms"};
      if (got.byte_offset !== want.byte_offset) diff = {diff, " byte_offset"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch in%s", diff);
          $display("  expected st %0d h %0d m %0d s %0d ms %0d tot %0d off %0d",
                   want.status, want.hours, want.minutes, want.seconds, want.millis,
                   want.target_ms, want.byte_offset);
          $display("  actual   st %0d h %0d m %0d s %0d ms %0d tot %0d off %0d",
                   got.status, got.hours, got.minutes, got.seconds, got.millis,
                   got.target_ms, got.byte_offset);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_timestamp_text_to_byte_offset_top.sv =====
`timescale 1ns / 1ps
// Testbench top: sends timestamp text requests to the seek block and checks every result.
module tb_timestamp_text_to_byte_offset_top;
  import tsbo_pkg::*;
  import tsbo_seek_sb_pkg::*;

  localparam int unsigned DrainCycles = 120;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned PhaseChars = 190;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ChW-1:0] in_ch = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [StW-1:0] out_status;
  logic [SegW-1:0] out_hours;
  logic [SegW-1:0] out_minutes;
  logic [SegW-1:0] out_seconds;
  logic [SegW-1:0] out_millis;
  logic [TotW-1:0] out_target_ms;
  logic [OffW-1:0] out_byte_offset;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  seek_scoreboard sb = new();
  seek_result_t seen;
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;
  int unsigned cycles = 0;
  int unsigned settings_used = 0;

  assign seen = {out_status, out_hours, out_minutes, out_seconds, out_millis,
                 out_target_ms, out_byte_offset};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  timestamp_text_to_byte_offset_top DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(seen);
      if (in_valid && !in_stall) sb.note_char(in_ch, in_last);
    end
  end

  // The result side stalls in random bursts, and once for a long stretch on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [ChW-1:0] c, input logic is_last);
    in_valid <= 1'b1;
    in_ch <= c;
    in_last <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_stamp(input logic [ChW-1:0] s[$]);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string t);
    logic [ChW-1:0] s[$];
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_stamp(s);
  endtask

  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CfgW-1:0] fsize, input logic [CfgW-1:0] dur);
    cfg_we <= 1'b1;
    cfg_index <= CfgFileSize;
    cfg_data <= fsize;
    sb.write_reg(CfgFileSize, fsize);
    @(posedge clk);
    cfg_index <= CfgDuration;
    cfg_data <= dur;
    sb.write_reg(CfgDuration, dur);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic void add_digits(ref logic [ChW-1:0] s[$]);
    int unsigned n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 3);
    repeat (n) s.push_back(ChZero + ChW'($urandom_range(0, 9)));
  endfunction

  // Most requests are well-formed timestamps; the rest are loose character soup.
  function automatic void build_stamp(ref logic [ChW-1:0] s[$]);
    int unsigned ncol;
    int unsigned len;
    int unsigned pick;
    if ($urandom_range(0, 99) < 75) begin
      do begin
        s.delete();
        ncol = $urandom_range(0, 2);
        add_digits(s);
        repeat (ncol) begin
          s.push_back(ChColon);
          add_digits(s);
        end
        if ($urandom_range(0, 1) == 1) begin
          s.push_back(ChDot);
          add_digits(s);
        end
      end while (s.size() > MaxLenDef && $urandom_range(0, 9) != 0);
    end else begin
      s.delete();
      len = $urandom_range(1, 18);
      repeat (len) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) s.push_back(ChZero + ChW'($urandom_range(0, 9)));
        else if (pick < 7) s.push_back(ChColon);
        else if (pick < 8) s.push_back(ChDot);
        else s.push_back(ChW'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic run_random(input int unsigned budget);
    logic [ChW-1:0] s[$];
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      build_stamp(s);
      send_stamp(s);
      sent += s.size();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Registers are still zero here, so these requests cannot seek.
    send_text("1:2:3.4");
    send_text("0");
    wait_idle();
    program_regs('1, 32'd1);
    send_text("99999999999999");
    send_text("x");
    send_text("1:");
    send_text("1.2:3");
    run_random(PhaseChars);

    wait_idle();
    program_regs('1, '1);
    run_random(PhaseChars);

    wait_idle();
    program_regs(32'd1, '1);
    run_random(PhaseChars / 2);
    wait_idle();
    run_random(PhaseChars / 2);

    wait_idle();
    program_regs($urandom, $urandom);
    run_random(20);
    hold_rx = 1'b1;
    run_random(PhaseChars - 20);

    wait_idle();
    program_regs('0, $urandom);
    run_random(PhaseChars);

    wait_idle();
    program_regs($urandom, '0);
    run_random(PhaseChars);

    wait_idle();
    program_regs($urandom_range(1, 1000), $urandom_range(1, 1000));
    run_random(PhaseChars);

    wait_idle();
    quiet = 1'b1;
    program_regs($urandom, $urandom_range(1, 100000));
    run_random(PhaseChars);
    wait_idle();

    $display("Seek results predicted: %0d ok, %0d bad format, %0d not seekable.",
             sb.seeks_ok, sb.seeks_bad, sb.seeks_noseek);
    $display("Register settings used: %0d; mismatches: %0d; still outstanding: %0d.",
             settings_used, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tsbo_pkg.sv
hdl/tsbo_ctrl.sv
hdl/tsbo_dp.sv
hdl/timestamp_text_to_byte_offset_top.sv
tb/sv/tsbo_seek_sb_pkg.sv
tb/sv/tb_timestamp_text_to_byte_offset_top.sv
